// File: rtl/fcmm_pkg.sv
// ----------------------------------------------------------------------------
// fcmm_pkg
// Shared constants, types and the CORDIC arctangent table of the mixer.
// ----------------------------------------------------------------------------
`default_nettype none
package fcmm_pkg;
  localparam int POWER_WIDTH_DEF = 16;
  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int SCALE_WIDTH = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int CW = 34;
  localparam logic signed [CW-1:0] CORDIC_INV_GAIN = 34'sd652032874;
  localparam logic signed [31:0] SQRT2_Q30 = 32'sd1518500250;
  localparam logic [0:0] ADDR_HEADLESS = 1'b0;

  typedef logic signed [CW-1:0] cord_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'h20000000;   5'd1: v = 32'h12E4051E;
      5'd2: v = 32'h09FB385B;   5'd3: v = 32'h051111D4;
      5'd4: v = 32'h028B0D43;   5'd5: v = 32'h0145D7E1;
      5'd6: v = 32'h00A2F61E;   5'd7: v = 32'h00517C55;
      5'd8: v = 32'h0028BE53;   5'd9: v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;  5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// File: rtl/fcmm_cordic_stage.sv
// ----------------------------------------------------------------------------
// fcmm_cordic_stage
// One registered CORDIC rotation step; forwards the item's payload.
// ----------------------------------------------------------------------------
`default_nettype none
module fcmm_cordic_stage #(
  parameter int STEP = 0,
  parameter int PW = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      vld_i,
  input  wire fcmm_pkg::cord_t           x_i,
  input  wire fcmm_pkg::cord_t           y_i,
  input  wire logic signed [32:0]        z_i,
  input  wire logic [PW-1:0]             pay_i,
  output logic                           vld_o,
  output fcmm_pkg::cord_t                x_o,
  output fcmm_pkg::cord_t                y_o,
  output logic signed [32:0]             z_o,
  output logic [PW-1:0]                  pay_o
);
  localparam logic [4:0] STEP_IDX = 5'(STEP);
  fcmm_pkg::cord_t xs, ys, x_nxt, y_nxt;
  logic signed [32:0] a, z_nxt;

  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
    a = $signed({1'b0, fcmm_pkg::atan_turn(STEP_IDX)});
    if (!z_i[32]) begin
      x_nxt = x_i - ys; y_nxt = y_i + xs; z_nxt = z_i - a;
    end else begin
      x_nxt = x_i + ys; y_nxt = y_i - xs; z_nxt = z_i + a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_o <= 1'b0;
    else vld_o <= vld_i;
    x_o <= x_nxt; y_o <= y_nxt; z_o <= z_nxt; pay_o <= pay_i;
  end
endmodule
`default_nettype wire

// File: rtl/fcmm_divider.sv
// ----------------------------------------------------------------------------
// fcmm_divider
// Pipelined restoring divider: round(mag * 2^(PW-1) / m), one bit per stage
// and a last stage that rounds.
// ----------------------------------------------------------------------------
`default_nettype none
module fcmm_divider #(
  parameter int PW = 16,
  parameter int DW = 20,
  parameter int SW = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          vld_i,
  input  wire logic [DW-1:0] mag_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [SW-1:0] side_i,
  output logic               vld_o,
  output logic [PW:0]        q_o,
  output logic [SW-1:0]      side_o
);
  localparam int N = PW;
  logic              v_r   [N+1];
  logic [DW:0]       rem_r [N+1];
  logic [DW-1:0]     den_r [N+1];
  logic [PW:0]       q_r   [N+1];
  logic [SW-1:0]     sd_r  [N+1];
  logic              q0;

  assign q0 = (mag_i >= den_i);

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else v_r[0] <= vld_i;
    rem_r[0] <= {1'b0, mag_i - (q0 ? den_i : '0)};
    q_r[0] <= (PW+1)'(q0);
    den_r[0] <= den_i;
    sd_r[0] <= side_i;
  end

  for (genvar k = 1; k <= N; k++) begin : g_st
    logic [DW+1:0] sh;
    logic          last;
    assign last = (k == N);
    always_comb sh = {rem_r[k-1], 1'b0};
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else v_r[k] <= v_r[k-1];
      den_r[k] <= den_r[k-1];
      sd_r[k] <= sd_r[k-1];
      if (!last) begin
        if (sh >= {2'b0, den_r[k-1]}) begin
          rem_r[k] <= (DW+1)'(sh - {2'b0, den_r[k-1]});
          q_r[k] <= {q_r[k-1][PW-1:0], 1'b1};
        end else begin
          rem_r[k] <= sh[DW:0];
          q_r[k] <= {q_r[k-1][PW-1:0], 1'b0};
        end
      end else begin
        rem_r[k] <= rem_r[k-1];
        q_r[k] <= q_r[k-1] + (PW+1)'(sh >= {2'b0, den_r[k-1]});
      end
    end
  end

  assign vld_o = v_r[N];
  assign q_o = q_r[N];
  assign side_o = sd_r[N];
endmodule
`default_nettype wire

// File: rtl/field_centric_mecanum_mixer.sv
// ----------------------------------------------------------------------------
// field_centric_mecanum_mixer
// Field-centric mecanum mixer: rotate (headless only), mix, normalize, scale, saturate.
// ----------------------------------------------------------------------------
// Usage: pulse start with the five command fields; busy is always low, so an
// item is taken every cycle it is offered. One result per item appears on the
// out_ ports for one cycle, marked by out_valid, in order. The receiver can
// not stall; it must take each result.
// Pipeline: 1 reduction stage, 24 CORDIC stages, 2 rotate stages, 1 sideways
// scale stage, 1 mix stage, 1 max stage, POWER_WIDTH+1 divider stages and 2
// scale stages. Throughput: one item/cycle, set by the fully pipelined CORDIC
// and divider.
// Reset (rst_n low, synchronous) clears all valid bits and sets
// headless_r to 1. Configuration through the APB port at address 0.
// ----------------------------------------------------------------------------
`default_nettype none
module field_centric_mecanum_mixer #(
  parameter int POWER_WIDTH = fcmm_pkg::POWER_WIDTH_DEF,
  parameter int ANGLE_WIDTH = fcmm_pkg::ANGLE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [POWER_WIDTH-1:0] in_forward_cmd,
  input  wire logic signed [POWER_WIDTH-1:0] in_sideways_cmd,
  input  wire logic signed [POWER_WIDTH-1:0] in_turn_cmd,
  input  wire logic [15:0]                   in_speed_scale,
  input  wire logic [ANGLE_WIDTH-1:0]        in_heading,
  output logic                               out_valid,
  output logic signed [POWER_WIDTH-1:0]      out_front_right_power,
  output logic signed [POWER_WIDTH-1:0]      out_front_left_power,
  output logic signed [POWER_WIDTH-1:0]      out_rear_right_power,
  output logic signed [POWER_WIDTH-1:0]      out_rear_left_power,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [1:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  localparam int PWD = POWER_WIDTH;
  localparam int SW = fcmm_pkg::SCALE_WIDTH;
  localparam int PAY = 3*PWD + SW + 1 + 2;
  localparam int NS = fcmm_pkg::CORDIC_STEPS;
  localparam int WW = PWD + 4;
  localparam int MW = 2*PWD + 40;

  logic headless_r;
  assign pready = 1'b1;
  assign busy = 1'b0;
  assign prdata = {31'b0, headless_r};
  always_ff @(posedge clk) begin
    if (!rst_n) headless_r <= 1'b1;
    else if (psel && penable && pwrite && paddr[1:0] == {fcmm_pkg::ADDR_HEADLESS, 1'b0})
      headless_r <= pwdata[0];
  end

  // stage 0: quadrant reduction
  logic [31:0] turn;
  logic [1:0] quad;
  logic [31:0] zr;
  assign turn = {in_heading, {(32-ANGLE_WIDTH){1'b0}}};
  assign quad = 2'((turn + 32'h20000000) >> 30);
  assign zr = turn - {quad, 30'b0};

  logic v0_r;
  fcmm_pkg::cord_t cx [NS+1];
  fcmm_pkg::cord_t cy [NS+1];
  logic signed [32:0] cz [NS+1];
  logic [PAY-1:0] cp [NS+1];
  logic cv [NS+1];
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else v0_r <= start;
    cx[0] <= fcmm_pkg::CORDIC_INV_GAIN;
    cy[0] <= '0;
    cz[0] <= $signed({zr[31], zr});
    cp[0] <= {in_forward_cmd, in_sideways_cmd, in_turn_cmd, in_speed_scale,
              headless_r, quad};
  end
  assign cv[0] = v0_r;

  for (genvar i = 0; i < NS; i++) begin : g_cor
    fcmm_cordic_stage #(.STEP(i), .PW(PAY)) u_st (
      .clk(clk), .rst_n(rst_n), .vld_i(cv[i]), .x_i(cx[i]), .y_i(cy[i]),
      .z_i(cz[i]), .pay_i(cp[i]), .vld_o(cv[i+1]), .x_o(cx[i+1]),
      .y_o(cy[i+1]), .z_o(cz[i+1]), .pay_o(cp[i+1]));
  end

  logic signed [PWD-1:0] f_c, s_c, t_c;
  logic [SW-1:0] sc_c;
  logic hl_c;
  logic [1:0] q_c;
  assign {f_c, s_c, t_c, sc_c, hl_c, q_c} = cp[NS];
  fcmm_pkg::cord_t cos_c, sin_c;
  always_comb begin
    case (q_c)
      2'd0: begin cos_c = cx[NS]; sin_c = cy[NS]; end
      2'd1: begin cos_c = -cy[NS]; sin_c = cx[NS]; end
      2'd2: begin cos_c = -cx[NS]; sin_c = -cy[NS]; end
      default: begin cos_c = cy[NS]; sin_c = -cx[NS]; end
    endcase
  end

  // rotate: products, then sums
  logic r1v_r;
  logic signed [MW-1:0] fc_r, ss_r, sc_r, fs_r;
  logic signed [PWD-1:0] r1f_r, r1s_r, r1t_r;
  logic [SW-1:0] r1sc_r;
  logic r1h_r;
  always_ff @(posedge clk) begin
    if (!rst_n) r1v_r <= 1'b0;
    else r1v_r <= cv[NS];
    fc_r <= MW'(f_c) * MW'(cos_c);
    ss_r <= MW'(s_c) * MW'(sin_c);
    sc_r <= MW'(s_c) * MW'(cos_c);
    fs_r <= MW'(f_c) * MW'(sin_c);
    r1f_r <= f_c; r1s_r <= s_c; r1t_r <= t_c; r1sc_r <= sc_c; r1h_r <= hl_c;
  end

  logic signed [MW-1:0] nf_c, ns_c;
  assign nf_c = (fc_r + ss_r + (MW'(1) <<< 29)) >>> 30;
  assign ns_c = (sc_r - fs_r + (MW'(1) <<< 29)) >>> 30;
  logic r2v_r;
  logic signed [WW-1:0] r2f_r, r2s_r, r2t_r;
  logic [SW-1:0] r2sc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) r2v_r <= 1'b0;
    else r2v_r <= r1v_r;
    r2f_r <= r1h_r ? WW'(nf_c) : WW'(r1f_r);
    r2s_r <= r1h_r ? WW'(ns_c) : WW'(r1s_r);
    r2t_r <= WW'(r1t_r);
    r2sc_r <= r1sc_r;
  end

  // sideways * sqrt(2)
  logic signed [MW-1:0] sq_c;
  assign sq_c = (MW'(r2s_r) * MW'(fcmm_pkg::SQRT2_Q30) + (MW'(1) <<< 29)) >>> 30;
  logic r3v_r;
  logic signed [WW-1:0] r3f_r, r3s_r, r3t_r;
  logic [SW-1:0] r3sc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) r3v_r <= 1'b0;
    else r3v_r <= r2v_r;
    r3f_r <= r2f_r; r3s_r <= WW'(sq_c); r3t_r <= r2t_r; r3sc_r <= r2sc_r;
  end

  // mix
  logic r4v_r;
  logic signed [WW-1:0] w_r [4];
  logic [SW-1:0] r4sc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) r4v_r <= 1'b0;
    else r4v_r <= r3v_r;
    w_r[0] <= r3f_r - r3s_r - r3t_r;
    w_r[1] <= r3f_r + r3s_r + r3t_r;
    w_r[2] <= r3f_r + r3s_r - r3t_r;
    w_r[3] <= r3f_r - r3s_r + r3t_r;
    r4sc_r <= r3sc_r;
  end

  // max magnitude
  logic [WW-1:0] a_c [4];
  logic [WW-1:0] m_c;
  always_comb begin
    m_c = '0;
    for (int k = 0; k < 4; k++) begin
      a_c[k] = w_r[k][WW-1] ? WW'(-w_r[k]) : WW'(w_r[k]);
      if (a_c[k] > m_c) m_c = a_c[k];
    end
  end
  logic r5v_r;
  logic [WW-1:0] r5a_r [4];
  logic [3:0] r5n_r;
  logic [WW-1:0] r5m_r;
  logic signed [WW-1:0] r5w_r [4];
  logic [SW-1:0] r5sc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) r5v_r <= 1'b0;
    else r5v_r <= r4v_r;
    for (int k = 0; k < 4; k++) begin
      r5a_r[k] <= a_c[k];
      r5n_r[k] <= w_r[k][WW-1];
      r5w_r[k] <= w_r[k];
    end
    r5m_r <= m_c;
    r5sc_r <= r4sc_r;
  end

  localparam int SIDE = 4*WW + 1 + SW + 4;
  logic norm_c;
  logic [WW-1:0] den_c;
  assign norm_c = r5m_r > (WW'(1) << (PWD-1));
  assign den_c = norm_c ? r5m_r : WW'(1);
  logic dv [4];
  logic [PWD:0] dq [4];
  logic [SIDE-1:0] dside;
  for (genvar k = 0; k < 4; k++) begin : g_div
    logic [SIDE-1:0] so;
    fcmm_divider #(.PW(PWD), .DW(WW), .SW(SIDE)) u_div (
      .clk(clk), .rst_n(rst_n), .vld_i(r5v_r), .mag_i(r5a_r[k]), .den_i(den_c),
      .side_i({r5w_r[0], r5w_r[1], r5w_r[2], r5w_r[3], norm_c, r5sc_r, r5n_r}),
      .vld_o(dv[k]), .q_o(dq[k]), .side_o(so));
    if (k == 0) begin : g_side
      assign dside = so;
    end
  end

  logic signed [WW-1:0] dw0, dw1, dw2, dw3;
  logic dnorm;
  logic [SW-1:0] dsc;
  logic [3:0] dneg;
  assign {dw0, dw1, dw2, dw3, dnorm, dsc, dneg} = dside;
  logic signed [WW-1:0] sel_c [4];
  always_comb begin
    sel_c[0] = dnorm ? (dneg[0] ? -WW'(dq[0]) : WW'(dq[0])) : dw0;
    sel_c[1] = dnorm ? (dneg[1] ? -WW'(dq[1]) : WW'(dq[1])) : dw1;
    sel_c[2] = dnorm ? (dneg[2] ? -WW'(dq[2]) : WW'(dq[2])) : dw2;
    sel_c[3] = dnorm ? (dneg[3] ? -WW'(dq[3]) : WW'(dq[3])) : dw3;
  end

  localparam int PRW = WW + SW + 2;
  logic r6v_r;
  logic signed [PRW-1:0] p_r [4];
  always_ff @(posedge clk) begin
    if (!rst_n) r6v_r <= 1'b0;
    else r6v_r <= dv[0];
    for (int k = 0; k < 4; k++)
      p_r[k] <= PRW'(sel_c[k]) * $signed({2'b0, dsc});
  end

  logic signed [PRW-1:0] v_c [4];
  logic signed [PWD-1:0] o_c [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      v_c[k] = (p_r[k] + (PRW'(1) <<< 14)) >>> 15;
      if (v_c[k] > PRW'((PRW'(1) <<< (PWD-1)) - 1))
        o_c[k] = {1'b0, {(PWD-1){1'b1}}};
      else if (v_c[k] < -(PRW'(1) <<< (PWD-1)))
        o_c[k] = {1'b1, {(PWD-1){1'b0}}};
      else
        o_c[k] = v_c[k][PWD-1:0];
    end
  end
  logic ov_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else ov_r <= r6v_r;
    out_front_right_power <= o_c[0];
    out_front_left_power <= o_c[1];
    out_rear_right_power <= o_c[2];
    out_rear_left_power <= o_c[3];
  end
  assign out_valid = ov_r;

  a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  a_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    r5v_r |-> ##(PWD+1) dv[0]) else $error("divider lost item");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    r6v_r |=> out_valid) else $error("output lost item");
  a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    (dv[0] == dv[1]) && (dv[0] == dv[2]) && (dv[0] == dv[3]))
    else $error("divider lanes out of step");
endmodule
`default_nettype wire

// File: tb/sv/field_centric_mecanum_mixer_tb.sv
// ----------------------------------------------------------------------------
// field_centric_mecanum_mixer_tb
// Self-checking bench for the mecanum mixer: directed corner items and random
// commands across headless on/off, predicted by a bit-accurate CORDIC/mixer
// model and checked in order against every out_valid strobe.
// ----------------------------------------------------------------------------
`default_nettype none
module field_centric_mecanum_mixer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = 16;
  localparam int AW = 16;
  localparam int PIPE_LAT = 49;
  localparam longint INV_GAIN = 652032874;
  localparam longint SQRT2 = 1518500250;

  typedef struct packed {
    logic signed [PW-1:0] fwd;
    logic signed [PW-1:0] side;
    logic signed [PW-1:0] turn;
    logic [15:0]          scale;
    logic [AW-1:0]        heading;
  } cmd_t;

  typedef struct packed {
    logic signed [PW-1:0] fr;
    logic signed [PW-1:0] fl;
    logic signed [PW-1:0] rr;
    logic signed [PW-1:0] rl;
  } wheels_t;

  logic clk, rst_n, start, busy;
  logic signed [PW-1:0] in_forward_cmd, in_sideways_cmd, in_turn_cmd;
  logic [15:0] in_speed_scale;
  logic [AW-1:0] in_heading;
  logic out_valid;
  logic signed [PW-1:0] out_front_right_power, out_front_left_power;
  logic signed [PW-1:0] out_rear_right_power, out_rear_left_power;
  logic psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;

  field_centric_mecanum_mixer u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_forward_cmd(in_forward_cmd), .in_sideways_cmd(in_sideways_cmd),
    .in_turn_cmd(in_turn_cmd), .in_speed_scale(in_speed_scale),
    .in_heading(in_heading), .out_valid(out_valid),
    .out_front_right_power(out_front_right_power),
    .out_front_left_power(out_front_left_power),
    .out_rear_right_power(out_rear_right_power),
    .out_rear_left_power(out_rear_left_power),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  cmd_t      pending_cmds[$];
  wheels_t   expected_wheels[$];
  bit        headless_on;
  int        errors, checked, gap_left;
  bit        hold_sender;
  longint    atan_tab[24];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint fshift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic void cordic_sin_cos(logic [31:0] turn32, output longint c,
                                         output longint s);
    logic [1:0]  quad;
    logic [31:0] zr;
    longint x, y, z, nx;
    quad = 2'((turn32 + 32'h2000_0000) >> 30);
    zr = turn32 - {quad, 30'b0};
    z = longint'($signed(zr));
    x = INV_GAIN;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = x - fshift(y, i);
        y = y + fshift(x, i);
        z -= atan_tab[i];
      end else begin
        nx = x + fshift(y, i);
        y = y - fshift(x, i);
        z += atan_tab[i];
      end
      x = nx;
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint norm_wheel(longint w, longint m);
    longint mag, q, rem;
    mag = (w < 0) ? -w : w;
    q = (mag >= m) ? 1 : 0;
    rem = mag - q * m;
    for (int i = 0; i < PW - 1; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= m) begin
        rem -= m;
        q |= 1;
      end
    end
    if (rem * 2 >= m) q++;
    return (w < 0) ? -q : q;
  endfunction

  function automatic logic signed [PW-1:0] scale_sat(longint w, logic [15:0] sc);
    longint v, lim;
    lim = longint'(1) << (PW - 1);
    v = (w * longint'(sc) + (longint'(1) << 14)) >>> 15;
    if (v > lim - 1) v = lim - 1;
    if (v < -lim) v = -lim;
    return PW'(v);
  endfunction

  function automatic wheels_t mix_wheels(cmd_t cmd);
    longint f, s, t, c, sn, nf, m, a;
    longint w[4];
    wheels_t r;
    f = cmd.fwd;
    s = cmd.side;
    t = cmd.turn;
    if (headless_on) begin
      cordic_sin_cos({cmd.heading, {(32 - AW){1'b0}}}, c, sn);
      nf = (f * c + s * sn + (longint'(1) << 29)) >>> 30;
      s = (s * c - f * sn + (longint'(1) << 29)) >>> 30;
      f = nf;
    end
    s = (s * SQRT2 + (longint'(1) << 29)) >>> 30;
    w[0] = f - s - t;
    w[1] = f + s + t;
    w[2] = f + s - t;
    w[3] = f - s + t;
    m = 0;
    for (int k = 0; k < 4; k++) begin
      a = (w[k] < 0) ? -w[k] : w[k];
      if (a > m) m = a;
    end
    if (m > (longint'(1) << (PW - 1)))
      for (int k = 0; k < 4; k++) w[k] = norm_wheel(w[k], m);
    r.fr = scale_sat(w[0], cmd.scale);
    r.fl = scale_sat(w[1], cmd.scale);
    r.rr = scale_sat(w[2], cmd.scale);
    r.rl = scale_sat(w[3], cmd.scale);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && busy) begin
    end else if (gap_left > 0 || hold_sender || pending_cmds.size() == 0) begin
      start <= 1'b0;
      if (gap_left > 0) gap_left <= gap_left - 1;
    end else begin
      cmd_t cmd;
      cmd = pending_cmds.pop_front();
      start <= 1'b1;
      in_forward_cmd <= cmd.fwd;
      in_sideways_cmd <= cmd.side;
      in_turn_cmd <= cmd.turn;
      in_speed_scale <= cmd.scale;
      in_heading <= cmd.heading;
      expected_wheels.push_back(mix_wheels(cmd));
      case ($urandom_range(0, 9))
        0, 1, 2: gap_left <= $urandom_range(1, 3);
        3: gap_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(20, 80) : 0;
        default: gap_left <= 0;
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_wheels.size() == 0) begin
        report_mismatch("unexpected item, fr wheel", out_front_right_power, 0);
      end else begin
        wheels_t e;
        e = expected_wheels.pop_front();
        checked++;
        if (out_front_right_power !== e.fr)
          report_mismatch("fr wheel", out_front_right_power, e.fr);
        if (out_front_left_power !== e.fl)
          report_mismatch("fl wheel", out_front_left_power, e.fl);
        if (out_rear_right_power !== e.rr)
          report_mismatch("rr wheel", out_rear_right_power, e.rr);
        if (out_rear_left_power !== e.rl)
          report_mismatch("rl wheel", out_rear_left_power, e.rl);
      end
    end
  end

  task automatic write_headless(bit val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 2'(fcmm_pkg::ADDR_HEADLESS); pwdata <= {31'b0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    headless_on = val;
  endtask

  task automatic drain_pipe();
    while (pending_cmds.size() != 0)
      @(posedge clk);
    hold_sender = 1'b1;
    while (expected_wheels.size() != 0 || start)
      @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
    hold_sender = 1'b0;
  endtask

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.fwd = PW'($urandom);
    c.side = PW'($urandom);
    c.turn = PW'($urandom);
    case ($urandom_range(0, 5))
      0: c.scale = 16'($urandom);
      1: c.scale = 16'd32768;
      default: c.scale = 16'($urandom_range(0, 32768));
    endcase
    c.heading = AW'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      c.fwd = PW'(int'($urandom_range(0, 255)) - 128);
      c.turn = '0;
    end
    return c;
  endfunction

  task automatic load_directed();
    logic signed [PW-1:0] mx, mn;
    mx = 16'sh7FFF;
    mn = 16'sh8000;
    pending_cmds.push_back('{mx, '0, '0, 16'd32768, 16'h0000});
    pending_cmds.push_back('{mn, mn, mn, 16'd32768, 16'h4000});
    pending_cmds.push_back('{mx, mx, mx, 16'hFFFF, 16'h8000});
    pending_cmds.push_back('{'0, mx, '0, 16'd32768, 16'hC000});
    pending_cmds.push_back('{16'sd16384, '0, 16'sd16384, 16'd32768, 16'h2000});
    pending_cmds.push_back('{mx, '0, '0, 16'hFFFF, 16'h6000});
    pending_cmds.push_back('{'0, '0, mx, 16'd0, 16'hFFFF});
    pending_cmds.push_back('{'0, '0, mn, 16'hFFFF, 16'hE000});
    pending_cmds.push_back('{mn, mx, '0, 16'd16384, 16'hA000});
    pending_cmds.push_back('{'0, '0, '0, 16'hFFFF, 16'h1234});
    pending_cmds.push_back('{16'sd100, -16'sd200, 16'sd50, 16'd32768, 16'h0001});
  endtask

  initial begin
    atan_tab = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                 64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                 64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517D,
                 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
                 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
    rst_n = 1'b0; start = 1'b0; hold_sender = 1'b1;
    in_forward_cmd = '0; in_sideways_cmd = '0; in_turn_cmd = '0;
    in_speed_scale = '0; in_heading = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    headless_on = 1'b1; errors = 0; checked = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // headless on from reset, then off, then on again via write
    hold_sender = 1'b0;
    load_directed();
    drain_pipe();
    write_headless(1'b0);
    load_directed();
    for (int i = 0; i < 240; i++) pending_cmds.push_back(rand_cmd());
    drain_pipe();
    write_headless(1'b1);
    for (int i = 0; i < 250; i++) pending_cmds.push_back(rand_cmd());
    drain_pipe();
    for (int i = 0; i < 240; i++) pending_cmds.push_back(rand_cmd());
    drain_pipe();
    $display("Checked %0d results over headless on/off phases, directed and random.",
             checked);
    if (errors == 0) begin
      $display("field_centric_mecanum_mixer_tb OK");
    end else begin
      $display("field_centric_mecanum_mixer_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("field_centric_mecanum_mixer_tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
rtl/fcmm_pkg.sv
rtl/fcmm_cordic_stage.sv
rtl/fcmm_divider.sv
rtl/field_centric_mecanum_mixer.sv
tb/sv/field_centric_mecanum_mixer_tb.sv
